/* hdl/lswc_pkg.sv */
// Shared widths, constants and helpers for the line segment window clipper.
package lswc_pkg;

	// Coordinate, window, difference and product widths.
	localparam int CW   = 40;
	localparam int WW   = 24;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int QW   = DW + 2;
	localparam int REMW = DW + 1;
	localparam int RW   = QW + 2;

	// Pipeline depths of the multiply-divide unit and of one clip lane.
	localparam int MD_LAT   = QW + 5;
	localparam int LANE_LAT = 2 * MD_LAT + 3;

	// Defaults for the top-level parameters.
	localparam int FRAC_BITS_DEF = 8;
	localparam int BIG_LIMIT_DEF = 32000;

	// Configuration port geometry and register map.
	localparam int AW     = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_TOP    = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_BOTTOM = 2'd3;

	// Window reset values.
	localparam logic signed [WW-1:0] RST_LEFT   = WW'(0);
	localparam logic signed [WW-1:0] RST_TOP    = WW'(0);
	localparam logic signed [WW-1:0] RST_RIGHT  = WW'(261888);
	localparam logic signed [WW-1:0] RST_BOTTOM = WW'(261888);

	// Magnitude of a signed difference; the most negative value maps correctly.
	function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
		logic [DW-1:0] r;
		r = v[DW-1] ? DW'(-v) : DW'(v);
		return r;
	endfunction

endpackage

/* hdl/lswc_muldiv.sv */
// Pipelined signed base + trunc(a * b / c) unit with a tag carried alongside.
module lswc_muldiv #(
	parameter int TAG_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic signed [lswc_pkg::DW-1:0]  dn,
	input  logic signed [lswc_pkg::DW-1:0]  off,
	input  logic signed [lswc_pkg::DW-1:0]  dd,
	input  logic signed [lswc_pkg::CW-1:0]  base,
	input  logic        [TAG_W-1:0]         tag,
	output logic                            out_vld,
	output logic signed [lswc_pkg::RW-1:0]  res,
	output logic        [TAG_W-1:0]         tag_out
);
	import lswc_pkg::*;

	localparam int LH   = (DW + 1) / 2;
	localparam int HI_W = DW - LH;

	// Stage 1: magnitudes, result sign and the zero-divisor case.
	logic                  vld_s1, neg_s1, zero_s1;
	logic [DW-1:0]         a_s1, b_s1, c_s1;
	logic signed [CW-1:0]  base_s1;
	logic [TAG_W-1:0]      tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= mag_of(dn);
			b_s1    <= mag_of(off);
			c_s1    <= mag_of(dd);
			neg_s1  <= (dn[DW-1] ^ off[DW-1]) ^ dd[DW-1];
			zero_s1 <= (dd == '0);
			base_s1 <= base;
			tag_s1  <= tag;
		end
	end

	// Stage 2: low partial products.
	logic                    vld_s2, neg_s2, zero_s2;
	logic [2*LH-1:0]         ll_s2;
	logic [LH+HI_W-1:0]      lh_s2;
	logic [HI_W-1:0]         ah_s2;
	logic [LH-1:0]           bl_s2;
	logic [HI_W-1:0]         bh_s2;
	logic [DW-1:0]           c_s2;
	logic signed [CW-1:0]    base_s2;
	logic [TAG_W-1:0]        tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s2   <= (2*LH)'(a_s1[LH-1:0]) * (2*LH)'(b_s1[LH-1:0]);
			lh_s2   <= (LH+HI_W)'(a_s1[LH-1:0]) * (LH+HI_W)'(b_s1[DW-1:LH]);
			ah_s2   <= a_s1[DW-1:LH];
			bl_s2   <= b_s1[LH-1:0];
			bh_s2   <= b_s1[DW-1:LH];
			c_s2    <= c_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			base_s2 <= base_s1;
			tag_s2  <= tag_s1;
		end
	end

	// Stage 3: high partial products and the first partial sum.
	logic                    vld_s3, neg_s3, zero_s3;
	logic [PW-1:0]           sum_s3;
	logic [LH+HI_W-1:0]      hl_s3;
	logic [2*HI_W-1:0]       hh_s3;
	logic [DW-1:0]           c_s3;
	logic signed [CW-1:0]    base_s3;
	logic [TAG_W-1:0]        tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= PW'(ll_s2) + (PW'(lh_s2) << LH);
			hl_s3   <= (LH+HI_W)'(ah_s2) * (LH+HI_W)'(bl_s2);
			hh_s3   <= (2*HI_W)'(ah_s2) * (2*HI_W)'(bh_s2);
			c_s3    <= c_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			base_s3 <= base_s2;
			tag_s3  <= tag_s2;
		end
	end

	// Stage 4: full product.
	logic                    vld_s4, neg_s4, zero_s4;
	logic [PW-1:0]           p_s4;
	logic [DW-1:0]           c_s4;
	logic signed [CW-1:0]    base_s4;
	logic [TAG_W-1:0]        tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4    <= sum_s3 + (PW'(hl_s3) << LH) + (PW'(hh_s3) << (2*LH));
			c_s4    <= c_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			base_s4 <= base_s3;
			tag_s4  <= tag_s3;
		end
	end

	// Restoring division, one quotient bit per stage.
	logic                   vld_sd  [QW];
	logic [REMW-1:0]        rem_sd  [QW];
	logic [QW-1:0]          q_sd    [QW];
	logic [QW-1:0]          low_sd  [QW];
	logic [DW-1:0]          c_sd    [QW];
	logic                   neg_sd  [QW];
	logic                   zero_sd [QW];
	logic signed [CW-1:0]   base_sd [QW];
	logic [TAG_W-1:0]       tag_sd  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic                  vld_i, neg_i, zero_i, ge;
		logic [REMW-1:0]       rem_i;
		logic [QW-1:0]         q_i, low_i;
		logic [DW-1:0]         c_i;
		logic signed [CW-1:0]  base_i;
		logic [TAG_W-1:0]      tag_i;
		logic [REMW:0]         sh;

		if (k == 0) begin : g_head
			assign vld_i  = vld_s4;
			assign rem_i  = REMW'(p_s4[PW-1:QW]);
			assign q_i    = '0;
			assign low_i  = p_s4[QW-1:0];
			assign c_i    = c_s4;
			assign neg_i  = neg_s4;
			assign zero_i = zero_s4;
			assign base_i = base_s4;
			assign tag_i  = tag_s4;
		end else begin : g_body
			assign vld_i  = vld_sd[k-1];
			assign rem_i  = rem_sd[k-1];
			assign q_i    = q_sd[k-1];
			assign low_i  = low_sd[k-1];
			assign c_i    = c_sd[k-1];
			assign neg_i  = neg_sd[k-1];
			assign zero_i = zero_sd[k-1];
			assign base_i = base_sd[k-1];
			assign tag_i  = tag_sd[k-1];
		end

		// Bring down the next product bit and try the subtraction.
		assign sh = {rem_i, low_i[QW-1]};
		assign ge = (sh >= (REMW+1)'(c_i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[k] <= 1'b0;
			else if (en) vld_sd[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k]  <= ge ? REMW'(sh - (REMW+1)'(c_i)) : REMW'(sh);
				q_sd[k]    <= {q_i[QW-2:0], ge};
				low_sd[k]  <= {low_i[QW-2:0], 1'b0};
				c_sd[k]    <= c_i;
				neg_sd[k]  <= neg_i;
				zero_sd[k] <= zero_i;
				base_sd[k] <= base_i;
				tag_sd[k]  <= tag_i;
			end
		end
	end

	// Final stage: apply the sign and add the base.
	logic signed [QW:0]    sq;
	logic                  vld_s5;
	logic signed [RW-1:0]  res_s5;
	logic [TAG_W-1:0]      tag_s5;

	assign sq = neg_sd[QW-1] ? -$signed({1'b0, q_sd[QW-1]}) : $signed({1'b0, q_sd[QW-1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_sd[QW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= zero_sd[QW-1] ? RW'(base_sd[QW-1])
			                        : RW'(base_sd[QW-1]) + RW'(sq);
			tag_s5 <= tag_sd[QW-1];
		end
	end

	assign out_vld = vld_s5;
	assign res     = res_s5;
	assign tag_out = tag_s5;

endmodule

/* hdl/lswc_lane.sv */
// Clip lane: clamps one endpoint flagged as big to the window with two line recomputes.
module lswc_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic signed [lswc_pkg::CW-1:0]  px,
	input  logic signed [lswc_pkg::CW-1:0]  py,
	input  logic signed [lswc_pkg::CW-1:0]  x0,
	input  logic signed [lswc_pkg::CW-1:0]  y0,
	input  logic signed [lswc_pkg::DW-1:0]  dx,
	input  logic signed [lswc_pkg::DW-1:0]  dy,
	input  logic                            big,
	input  logic signed [lswc_pkg::WW-1:0]  win_l,
	input  logic signed [lswc_pkg::WW-1:0]  win_t,
	input  logic signed [lswc_pkg::WW-1:0]  win_r,
	input  logic signed [lswc_pkg::WW-1:0]  win_b,
	output logic                            out_vld,
	output logic                            ok,
	output logic signed [lswc_pkg::WW-1:0]  qx,
	output logic signed [lswc_pkg::WW-1:0]  qy
);
	import lswc_pkg::*;

	typedef enum logic [1:0] {MD_NONE, MD_X, MD_Y} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic signed [WW-1:0]  edge_v;
		logic signed [WW-1:0]  ox;
		logic signed [WW-1:0]  oy;
		logic signed [CW-1:0]  x0;
		logic signed [CW-1:0]  y0;
		logic signed [DW-1:0]  dx;
		logic signed [DW-1:0]  dy;
	} first_tag_t;

	typedef struct packed {
		mode_t                 mode;
		logic signed [WW-1:0]  cx;
		logic signed [WW-1:0]  cy;
	} second_tag_t;

	// First clamp: choose the edge and set up the first recompute.
	mode_t                 mode_a;
	logic signed [WW-1:0]  edge_a;
	logic signed [DW-1:0]  dn_a, off_a, dd_a;
	logic signed [CW-1:0]  base_a;

	always_comb begin
		mode_a = MD_NONE;
		edge_a = win_l;
		if (big) begin
			if (px < win_l) begin
				mode_a = MD_X;
				edge_a = win_l;
			end else if (px > win_r) begin
				mode_a = MD_X;
				edge_a = win_r;
			end else if (py < win_t) begin
				mode_a = MD_Y;
				edge_a = win_t;
			end else if (py > win_b) begin
				mode_a = MD_Y;
				edge_a = win_b;
			end
		end
		if (mode_a == MD_Y) begin
			dn_a   = dx;
			off_a  = DW'(edge_a) - DW'(y0);
			dd_a   = dy;
			base_a = x0;
		end else begin
			dn_a   = dy;
			off_a  = DW'(edge_a) - DW'(x0);
			dd_a   = dx;
			base_a = y0;
		end
	end

	logic                  vld_s2;
	logic signed [DW-1:0]  dn_s2, off_s2, dd_s2;
	logic signed [CW-1:0]  base_s2;
	first_tag_t            t1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s2         <= dn_a;
			off_s2        <= off_a;
			dd_s2         <= dd_a;
			base_s2       <= base_a;
			t1_s2.mode    <= mode_a;
			t1_s2.edge_v  <= edge_a;
			t1_s2.ox      <= WW'(px);
			t1_s2.oy      <= WW'(py);
			t1_s2.x0      <= x0;
			t1_s2.y0      <= y0;
			t1_s2.dx      <= dx;
			t1_s2.dy      <= dy;
		end
	end

	logic                  vld_m1;
	logic signed [RW-1:0]  r1;
	first_tag_t            t1;

	lswc_muldiv #(
		.TAG_W ($bits(first_tag_t))
	) u_md1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.dn      (dn_s2),
		.off     (off_s2),
		.dd      (dd_s2),
		.base    (base_s2),
		.tag     (t1_s2),
		.out_vld (vld_m1),
		.res     (r1),
		.tag_out (t1)
	);

	// Second clamp: keep the point if inside, else clamp the other axis.
	second_tag_t           t2_b;
	logic signed [DW-1:0]  dn_b, off_b, dd_b;
	logic signed [CW-1:0]  base_b;

	always_comb begin
		t2_b.mode = MD_NONE;
		t2_b.cx   = t1.ox;
		t2_b.cy   = t1.oy;
		dn_b      = t1.dx;
		dd_b      = t1.dy;
		base_b    = t1.x0;
		case (t1.mode)
			MD_X: begin
				t2_b.mode = MD_X;
				t2_b.cx   = t1.edge_v;
				if (r1 < win_t) begin
					t2_b.cy = win_t;
				end else if (r1 > win_b) begin
					t2_b.cy = win_b;
				end else begin
					t2_b.mode = MD_NONE;
					t2_b.cy   = WW'(r1);
				end
			end
			MD_Y: begin
				t2_b.mode = MD_Y;
				t2_b.cy   = t1.edge_v;
				if (r1 < win_l) begin
					t2_b.cx = win_l;
				end else if (r1 > win_r) begin
					t2_b.cx = win_r;
				end else begin
					t2_b.mode = MD_NONE;
					t2_b.cx   = WW'(r1);
				end
			end
			default: begin
				t2_b.mode = MD_NONE;
			end
		endcase
		if (t1.mode == MD_Y) begin
			dn_b   = t1.dy;
			off_b  = DW'(t2_b.cx) - DW'(t1.x0);
			dd_b   = t1.dx;
			base_b = t1.y0;
		end else begin
			off_b  = DW'(t2_b.cy) - DW'(t1.y0);
		end
	end

	logic                  vld_s3;
	logic signed [DW-1:0]  dn_s3, off_s3, dd_s3;
	logic signed [CW-1:0]  base_s3;
	second_tag_t           t2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_m1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s3   <= dn_b;
			off_s3  <= off_b;
			dd_s3   <= dd_b;
			base_s3 <= base_b;
			t2_s3   <= t2_b;
		end
	end

	logic                  vld_m2;
	logic signed [RW-1:0]  r2;
	second_tag_t           t2;

	lswc_muldiv #(
		.TAG_W ($bits(second_tag_t))
	) u_md2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.dn      (dn_s3),
		.off     (off_s3),
		.dd      (dd_s3),
		.base    (base_s3),
		.tag     (t2_s3),
		.out_vld (vld_m2),
		.res     (r2),
		.tag_out (t2)
	);

	// Final check of the recomputed coordinate.
	logic                  ok_c;
	logic signed [WW-1:0]  fx_c, fy_c;

	always_comb begin
		ok_c = 1'b1;
		fx_c = t2.cx;
		fy_c = t2.cy;
		case (t2.mode)
			MD_X: begin
				ok_c = (r2 >= win_l) && (r2 <= win_r);
				fx_c = WW'(r2);
			end
			MD_Y: begin
				ok_c = (r2 >= win_t) && (r2 <= win_b);
				fy_c = WW'(r2);
			end
			default: begin
				ok_c = 1'b1;
			end
		endcase
	end

	logic                  vld_s4, ok_s4;
	logic signed [WW-1:0]  x_s4, y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_m2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4 <= ok_c;
			x_s4  <= fx_c;
			y_s4  <= fy_c;
		end
	end

	assign out_vld = vld_s4;
	assign ok      = ok_s4;
	assign qx      = x_s4;
	assign qy      = y_s4;

endmodule

/* hdl/line_segment_window_clipper.sv */
// Top level of the line segment window clipper: window registers and pipeline.
// An accepted input beat passes the input register, both clip lanes and the output register.
// Throughput: one segment per cycle; the whole pipeline advances whenever the
// output register is empty or taken, so a stall freezes every stage in place.
// Each endpoint lane holds two multiply-divide units of one quotient bit per stage.
// Reset clears all valid bits and loads the default window (0, 0, 261888, 261888).
module line_segment_window_clipper #(
	parameter int FRAC_BITS = lswc_pkg::FRAC_BITS_DEF,
	parameter int BIG_LIMIT = lswc_pkg::BIG_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lswc_pkg::AW-1:0]           paddr,
	input  logic [lswc_pkg::DATA_W-1:0]       pwdata,
	output logic [lswc_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	// Input segments.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: start_x[39:0], start_y[79:40], end_x[119:80], end_y[159:120]
	input  logic [4*lswc_pkg::CW-1:0]         s_tdata,
	// Clipped segments.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: out_start_x[23:0], out_start_y[47:24], out_end_x[71:48], out_end_y[95:72]
	output logic [4*lswc_pkg::WW-1:0]         m_tdata,
	// m_tuser: visible[0]
	output logic                              m_tuser
);
	import lswc_pkg::*;

	localparam logic signed [63:0] BIG_LIM = 64'(BIG_LIMIT) <<< FRAC_BITS;

	// Window registers.
	logic signed [WW-1:0] win_l_q, win_t_q, win_r_q, win_b_q;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l_q <= RST_LEFT;
			win_t_q <= RST_TOP;
			win_r_q <= RST_RIGHT;
			win_b_q <= RST_BOTTOM;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LEFT:   win_l_q <= pwdata[WW-1:0];
				REG_TOP:    win_t_q <= pwdata[WW-1:0];
				REG_RIGHT:  win_r_q <= pwdata[WW-1:0];
				REG_BOTTOM: win_b_q <= pwdata[WW-1:0];
				default:    win_l_q <= win_l_q;
			endcase
		end
	end

	// Register read back, sign extended.
	always_comb begin
		case (paddr[3:2])
			REG_LEFT:   prdata = DATA_W'(win_l_q);
			REG_TOP:    prdata = DATA_W'(win_t_q);
			REG_RIGHT:  prdata = DATA_W'(win_r_q);
			REG_BOTTOM: prdata = DATA_W'(win_b_q);
			default:    prdata = '0;
		endcase
	end

	// Pipeline advance: the output register is empty or being taken.
	logic out_vld_q;
	logic adv;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	// Stage 1: capture the input beat.
	logic                  vld_s1;
	logic signed [CW-1:0]  sx_s1, sy_s1, ex_s1, ey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= s_tdata[CW-1:0];
			sy_s1 <= s_tdata[2*CW-1:CW];
			ex_s1 <= s_tdata[3*CW-1:2*CW];
			ey_s1 <= s_tdata[4*CW-1:3*CW];
		end
	end

	// Trivial rejection, big endpoint tests and direction.
	logic                  rej, big0, big1;
	logic signed [63:0]    sx64, sy64, ex64, ey64;
	logic signed [DW-1:0]  dx, dy;

	assign sx64 = 64'(sx_s1);
	assign sy64 = 64'(sy_s1);
	assign ex64 = 64'(ex_s1);
	assign ey64 = 64'(ey_s1);

	assign rej = ((sx_s1 < win_l_q) && (ex_s1 < win_l_q)) ||
	             ((sx_s1 > win_r_q) && (ex_s1 > win_r_q)) ||
	             ((sy_s1 < win_t_q) && (ey_s1 < win_t_q)) ||
	             ((sy_s1 > win_b_q) && (ey_s1 > win_b_q));
	assign big0 = (sx64 > BIG_LIM) || (sx64 < -BIG_LIM) || (sy64 > BIG_LIM) || (sy64 < -BIG_LIM);
	assign big1 = (ex64 > BIG_LIM) || (ex64 < -BIG_LIM) || (ey64 > BIG_LIM) || (ey64 < -BIG_LIM);
	assign dx   = DW'(ex_s1) - DW'(sx_s1);
	assign dy   = DW'(ey_s1) - DW'(sy_s1);

	// One lane for each endpoint; both run side by side.
	logic                  e_vld, e_ok, s_vld, s_ok;
	logic signed [WW-1:0]  e_x, e_y, s_x, s_y;

	lswc_lane u_lane_end (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s1),
		.px      (ex_s1),
		.py      (ey_s1),
		.x0      (sx_s1),
		.y0      (sy_s1),
		.dx      (dx),
		.dy      (dy),
		.big     (big1),
		.win_l   (win_l_q),
		.win_t   (win_t_q),
		.win_r   (win_r_q),
		.win_b   (win_b_q),
		.out_vld (e_vld),
		.ok      (e_ok),
		.qx      (e_x),
		.qy      (e_y)
	);

	lswc_lane u_lane_start (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s1),
		.px      (sx_s1),
		.py      (sy_s1),
		.x0      (sx_s1),
		.y0      (sy_s1),
		.dx      (dx),
		.dy      (dy),
		.big     (big0),
		.win_l   (win_l_q),
		.win_t   (win_t_q),
		.win_r   (win_r_q),
		.win_b   (win_b_q),
		.out_vld (s_vld),
		.ok      (s_ok),
		.qx      (s_x),
		.qy      (s_y)
	);

	// Rejection flag delayed to match the lanes.
	logic rej_dly_q [LANE_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			rej_dly_q[0] <= rej;
			for (int k = 1; k < LANE_LAT; k++) begin
				rej_dly_q[k] <= rej_dly_q[k-1];
			end
		end
	end

	// Output register: combine both lanes, zero the coordinates when rejected or when a lane check fails.
	logic                  keep;
	logic                  vis_q;
	logic [4*WW-1:0]       data_q;

	assign keep = !rej_dly_q[LANE_LAT-1] && e_ok && s_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= e_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_q  <= keep;
			data_q <= keep ? {e_y, e_x, s_y, s_x} : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = vis_q;

	// A rejected beat never carries coordinates.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("rejected segment with nonzero coordinates");

	// Both endpoint lanes stay in lock step.
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		e_vld == s_vld)
		else $error("endpoint lanes out of step");

	// An accepted beat occupies the first stage on the next cycle.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted beat lost at the first stage");

endmodule

/* dv/tb_line_segment_window_clipper.sv */
// Self-checking testbench for the line segment window clipper.
`timescale 1ns / 1ps

module tb_line_segment_window_clipper;
	import lswc_pkg::*;

	localparam int  LIMIT_CYCLES = 1000000;
	localparam int  DRAIN_CYCLES = 2 * MD_LAT + 20;
	localparam longint BIG_EDGE  = longint'(BIG_LIMIT_DEF) <<< FRAC_BITS_DEF;

	typedef enum int {CLAMP_NONE, CLAMP_X, CLAMP_Y} clamp_axis_t;

	typedef struct {
		logic signed [CW-1:0] sx, sy, ex, ey;
	} segment_t;

	typedef struct {
		logic          visible;
		logic [WW-1:0] sx, sy, ex, ey;
	} clipped_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel, penable, pwrite;
	logic [AW-1:0]        paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 s_tvalid, s_tready;
	// s_tdata: start_x, start_y, end_x, end_y (40 bits each, from bit 0 up)
	logic [4*CW-1:0]      s_tdata;
	logic                 m_tvalid, m_tready;
	// m_tdata: out_start_x, out_start_y, out_end_x, out_end_y (24 bits each)
	logic [4*WW-1:0]      m_tdata;
	// m_tuser: visible
	logic                 m_tuser;

	line_segment_window_clipper dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Shadow copy of the window registers.
	longint win_left, win_top, win_right, win_bottom;

	segment_t pending_segs[$];
	clipped_t expected_clips[$];
	int       fail_count;
	int       seg_count, kept_count, cut_count;
	int       cycle_count;
	bit       seg_taken;
	int       burst_left, gap_left;
	int       hold_cycles;
	int       stall_mode, stall_left;

	always #5 clk = ~clk;

	// One point along the line: base + trunc(dn * off / dd), quotient magnitude capped at 2^62.
	function automatic longint line_at(longint dn, longint off, longint dd, longint base);
		logic signed [127:0] a, b, p;
		logic [127:0] pm, dm, q;
		longint r;
		bit neg;
		if (dd == 0)
			return base;
		a = dn;
		b = off;
		p = a * b;
		pm = p[127] ? -p : p;
		dm = (dd < 0) ? 128'(-dd) : 128'(dd);
		q = pm / dm;
		if (q > (128'd1 << 62))
			q = 128'd1 << 62;
		neg = (dn < 0) ^ (off < 0) ^ (dd < 0);
		r = longint'(q[63:0]);
		return (neg ? -r : r) + base;
	endfunction

	// Clamp one endpoint into the window along the original line; 0 means rejected.
	function automatic bit clip_point(inout longint x, inout longint y,
			input longint x0, input longint y0, input longint dx, input longint dy);
		longint nx, ny;
		clamp_axis_t axis;
		nx = x;
		ny = y;
		axis = CLAMP_NONE;
		if (nx < win_left) begin
			nx = win_left; axis = CLAMP_X;
		end else if (nx > win_right) begin
			nx = win_right; axis = CLAMP_X;
		end else if (ny < win_top) begin
			ny = win_top; axis = CLAMP_Y;
		end else if (ny > win_bottom) begin
			ny = win_bottom; axis = CLAMP_Y;
		end
		if (axis == CLAMP_X) begin
			ny = line_at(dy, nx - x0, dx, y0);
			if (ny < win_top) ny = win_top;
			else if (ny > win_bottom) ny = win_bottom;
			else axis = CLAMP_NONE;
		end else if (axis == CLAMP_Y) begin
			nx = line_at(dx, ny - y0, dy, x0);
			if (nx < win_left) nx = win_left;
			else if (nx > win_right) nx = win_right;
			else axis = CLAMP_NONE;
		end
		// A second clamp moves the point back onto the line, which must stay inside.
		if (axis == CLAMP_X) begin
			nx = line_at(dx, ny - y0, dy, x0);
			if (nx < win_left || nx > win_right) return 0;
		end else if (axis == CLAMP_Y) begin
			ny = line_at(dy, nx - x0, dx, y0);
			if (ny < win_top || ny > win_bottom) return 0;
		end
		x = nx;
		y = ny;
		return 1;
	endfunction

	function automatic bit is_big(longint x, longint y);
		return x > BIG_EDGE || x < -BIG_EDGE || y > BIG_EDGE || y < -BIG_EDGE;
	endfunction

	// Expected clipped segment for one input segment under the current window.
	function automatic clipped_t clip_segment(segment_t s);
		longint sx, sy, ex, ey, x0, y0, dx, dy;
		bit ok, big_start, big_end;
		clipped_t r;
		sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
		x0 = sx; y0 = sy; dx = ex - sx; dy = ey - sy;
		ok = 1;
		if ((sx < win_left && ex < win_left) || (sx > win_right && ex > win_right) ||
				(sy < win_top && ey < win_top) || (sy > win_bottom && ey > win_bottom)) begin
			ok = 0;
		end else begin
			big_start = is_big(sx, sy);
			big_end = is_big(ex, ey);
			if (big_end) ok = clip_point(ex, ey, x0, y0, dx, dy);
			if (big_start && ok) ok = clip_point(sx, sy, x0, y0, dx, dy);
		end
		if (!ok) begin
			sx = 0; sy = 0; ex = 0; ey = 0;
		end
		r.visible = ok;
		r.sx = sx[WW-1:0];
		r.sy = sy[WW-1:0];
		r.ex = ex[WW-1:0];
		r.ey = ey[WW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [WW-1:0] got,
			input logic [WW-1:0] want);
		fail_count++;
		$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
	endtask

	// Input driver: bursts of beats separated by random gaps.
	always @(negedge clk) begin
		segment_t s;
		if (!s_tvalid || seg_taken) begin
			seg_taken = 0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_segs.size() > 0) begin
				s = pending_segs.pop_front();
				s_tdata <= {s.ey, s.ex, s.sy, s.sx};
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off when asked, otherwise a changing stall pattern.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(64, 512);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Accepted input beats become expectations; result beats are checked against them.
	always @(posedge clk) begin
		clipped_t want;
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_line_segment_window_clipper NOT OK");
			$finish;
		end
		if (s_tvalid && s_tready) begin
			seg_taken = 1;
			seg_count++;
			expected_clips.push_back(clip_segment('{s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
				s_tdata[3*CW-1:2*CW], s_tdata[4*CW-1:3*CW]}));
		end
		if (m_tvalid && m_tready) begin
			if (expected_clips.size() == 0) begin
				fail_count++;
				$display("[%0t] result beat with nothing expected", $realtime);
			end else begin
				want = expected_clips.pop_front();
				if (want.visible) kept_count++;
				else cut_count++;
				if (m_tuser !== want.visible)
					report_mismatch("visible", WW'(m_tuser), WW'(want.visible));
				if (m_tdata[WW-1:0] !== want.sx)
					report_mismatch("out_start_x", m_tdata[WW-1:0], want.sx);
				if (m_tdata[2*WW-1:WW] !== want.sy)
					report_mismatch("out_start_y", m_tdata[2*WW-1:WW], want.sy);
				if (m_tdata[3*WW-1:2*WW] !== want.ex)
					report_mismatch("out_end_x", m_tdata[3*WW-1:2*WW], want.ex);
				if (m_tdata[4*WW-1:3*WW] !== want.ey)
					report_mismatch("out_end_y", m_tdata[4*WW-1:3*WW], want.ey);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input longint value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = AW'({idx, 2'b00});
		pwdata = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_LEFT:   win_left = value;
			REG_TOP:    win_top = value;
			REG_RIGHT:  win_right = value;
			default:    win_bottom = value;
		endcase
	endtask

	task automatic set_window(input longint l, input longint t, input longint r,
			input longint b);
		write_reg(REG_LEFT, l);
		write_reg(REG_TOP, t);
		write_reg(REG_RIGHT, r);
		write_reg(REG_BOTTOM, b);
	endtask

	task automatic push_seg(input longint sx, input longint sy, input longint ex,
			input longint ey);
		pending_segs.push_back('{sx[CW-1:0], sy[CW-1:0], ex[CW-1:0], ey[CW-1:0]});
	endtask

	// Wait until every expected result has arrived and the pipeline is quiet.
	task automatic wait_drained();
		while (pending_segs.size() > 0 || s_tvalid || expected_clips.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Coordinate near the window, in the unclipped range, or anywhere in 40 bits.
	function automatic longint rand_coord(input int kind);
		longint v;
		case (kind)
			0: v = longint'($urandom_range(0, 1200000)) - 400000;
			1: v = longint'($urandom_range(0, 2 * 8192000)) - 8192000;
			default: begin
				v = {$urandom(), $urandom()};
				v = longint'($signed(v[CW-1:0]));
			end
		endcase
		return v;
	endfunction

	task automatic push_random(input int n);
		int k0, k1;
		repeat (n) begin
			k0 = $urandom_range(0, 2);
			k1 = $urandom_range(0, 2);
			if ($urandom_range(0, 7) == 0) begin
				// Axis-parallel line exercises the zero-difference path.
				push_seg(1000, rand_coord(k0), 1000, rand_coord(k1));
			end else begin
				push_seg(rand_coord(k0), rand_coord(k0), rand_coord(k1), rand_coord(k1));
			end
		end
	endtask

	initial begin
		longint cmax, cmin;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		fail_count = 0; seg_count = 0; kept_count = 0; cut_count = 0; cycle_count = 0;
		seg_taken = 0; burst_left = 0; gap_left = 0; hold_cycles = 0;
		stall_mode = 0; stall_left = 0;
		win_left = RST_LEFT; win_top = RST_TOP; win_right = RST_RIGHT; win_bottom = RST_BOTTOM;
		cmax = (longint'(1) <<< (CW - 1)) - 1;
		cmin = -(longint'(1) <<< (CW - 1));
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed segments under the reset window.
		push_seg(1000, 2000, 5000, 6000);
		push_seg(-5, -100, -1, 3000);
		push_seg(300000, 5, 400000, 7);
		push_seg(5, -10, 7, -20);
		push_seg(5, 300000, 7, 300000);
		push_seg(1000, 1000, 20000000, 1000);
		push_seg(-20000000, 5000, 100000, 5000);
		push_seg(-20000000, -20000000, 20000000, 20000000);
		push_seg(5000, -30000000, 5000, 30000000);
		push_seg(cmax, cmax, cmin, cmin);
		push_seg(cmin, cmax, cmax, cmin);
		push_seg(0, 0, 0, 0);
		push_seg(-20000000, 500000, 500000, -20000000);
		push_seg(8192000, 8192000, -8192000, -8192000);
		push_seg(8192001, 100, 100, 100);
		push_seg(100, -8192001, 100, 200);
		push_seg(-30000000, 130000, 30000000, 130000);
		push_seg(cmin, 0, cmax, 0);
		push_random(200);
		wait_drained();

		// Widest window, with a long receiver hold-off to fill the pipeline.
		set_window(-8192000, -8192000, 8192000, 8192000);
		push_random(250);
		hold_cycles = 600;
		wait_drained();

		// Narrow window.
		set_window(1000, -2000, 1500, 4000);
		push_random(220);
		wait_drained();

		// Inverted window.
		set_window(200000, 0, 100000, 261888);
		push_random(150);
		wait_drained();

		// Random windows, then two fixed windows.
		repeat (3) begin
			set_window(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
			push_random(60);
			wait_drained();
		end
		set_window(-8192000, 8192000, 8192000, -8192000);
		push_random(100);
		wait_drained();
		set_window(-300000, -300000, 500000, 500000);
		push_random(200);
		wait_drained();

		$display("segments sent: %0d, results kept: %0d, rejected: %0d",
			seg_count, kept_count, cut_count);
		$display("window settings covered: reset, widest, narrow, inverted and random");
		if (fail_count == 0) begin
			$display("tb_line_segment_window_clipper OK");
		end else begin
			$display("tb_line_segment_window_clipper NOT OK");
		end
		$finish;
	end

endmodule

/* line_segment_window_clipper.f */
hdl/lswc_pkg.sv
hdl/lswc_muldiv.sv
hdl/lswc_lane.sv
hdl/line_segment_window_clipper.sv
dv/tb_line_segment_window_clipper.sv
